/* rtl/frsn_pkg.sv */
// shared types, constants and coefficient tables for the fresnel integral pipeline
package frsn_pkg;

   localparam int NUM_MODES    = 4;
   localparam int NUM_POLYS    = 4;
   localparam int HORNER_TERMS = 7;
   localparam int HORNER_STEPS = HORNER_TERMS - 1;
   // one register for the leading term, then a product and a sum register per step
   localparam int HORNER_LAT   = 2 * HORNER_STEPS + 1;
   localparam int FRAC_BITS    = 30;
   localparam int DIV_STEPS    = 64 + FRAC_BITS;
   localparam int CORDIC_STEPS = 30;
   localparam int CORD_W       = 34;
   localparam int COEF_COUNT   = NUM_MODES * NUM_POLYS * HORNER_TERMS;
   localparam int COEF_IDX_W   = $clog2(COEF_COUNT);

   localparam int POLY_A = 0;
   localparam int POLY_B = 1;
   localparam int POLY_C = 2;
   localparam int POLY_D = 3;

   typedef logic [1:0]               mode_type;
   typedef logic [30:0]              arg_type;
   typedef logic [63:0]              acc_type;
   typedef logic [62:0]              prod_type;
   typedef logic [31:0]              quot_type;
   typedef logic [25:0]              coef_type;
   typedef logic signed [CORD_W-1:0] cord_type;
   typedef coef_type                 coef_tab_type [0:COEF_COUNT-1];

   localparam mode_type MODE_RESET = 2'd3;

   // decimal coefficients scaled by 1e8, ordered mode, polynomial, leading term first
   localparam longint unsigned COEF_DEC [0:COEF_COUNT-1] = '{
      0, 0, 0, 0, 0, 0, 100000000,
      0, 0, 0, 80300000, 188600000, 252400000, 200000000,
      0, 0, 0, 0, 0, 50600000, 100000000,
      0, 0, 0, 0, 179000000, 205400000, 141421356,
      0, 0, 0, 0, 0, 17650000, 100000000,
      0, 0, 0, 151900000, 207900000, 291500000, 200000000,
      0, 0, 0, 0, 35690000, 50830000, 100000000,
      0, 0, 0, 110210000, 185150000, 214160000, 141421356,
      0, 0, 0, 0, 15108000, 8218000, 100000000,
      0, 0, 65610000, 123890000, 231850000, 270970000, 200000000,
      0, 0, 0, 19170000, 41159000, 60427000, 100000000,
      0, 0, 60353000, 126057000, 215594000, 226794000, 141421356,
      0, 0, 2412120, 6832400, 23636410, 19451610, 100000000,
      11824700, 35668100, 97811300, 187572100, 275704600, 293550410, 200000000,
      0, 4339950, 13392590, 34605090, 64601170, 77695070, 100000000,
      13634704, 42052170, 109173250, 198405240, 271967410, 251298060, 141421356
   };

   // round to nearest into q24
   function automatic coef_type coef_q24(input longint unsigned dec);
      longint unsigned scaled;
      scaled = (dec * 64'd16777216 + 64'd50000000) / 64'd100000000;
      return coef_type'(scaled);
   endfunction

   function automatic coef_tab_type make_coef_tab();
      coef_tab_type tab;
      for (int i = 0; i < COEF_COUNT; i++) begin
         tab[i] = coef_q24(COEF_DEC[i]);
      end
      return tab;
   endfunction

   localparam coef_tab_type COEF_Q24 = make_coef_tab();

   function automatic coef_type coef_at(input mode_type mode, input int poly, input int term);
      logic [COEF_IDX_W-1:0] idx;
      idx = COEF_IDX_W'(mode) * COEF_IDX_W'(NUM_POLYS * HORNER_TERMS)
          + COEF_IDX_W'(poly * HORNER_TERMS + term);
      return COEF_Q24[idx];
   endfunction

   localparam logic [63:0] SQRT2PI_WIDE =
      (64'd797884561 * 64'd4294967296 + 64'd500000000) / 64'd1000000000;
   localparam logic [63:0] SQRTPI2_WIDE =
      (64'd12533141373 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
   localparam logic [63:0] SQRTPI8_WIDE =
      (64'd6266570687 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;

   localparam logic [31:0] SQRT2PI_Q32 = SQRT2PI_WIDE[31:0];
   localparam logic [30:0] SQRTPI2_Q30 = SQRTPI2_WIDE[30:0];
   localparam logic [29:0] SQRTPI8_Q30 = SQRTPI8_WIDE[29:0];
   localparam logic [30:0] HALFPI_Q30  = 31'd1686629713;
   localparam cord_type    CORDIC_K    = 34'sd652032875;

   localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159, 30'd67021688,
      30'd33543515, 30'd16775850, 30'd8388438, 30'd4194283, 30'd2097150,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
      30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
      30'd1024, 30'd512, 30'd256, 30'd128, 30'd64,
      30'd32, 30'd16, 30'd8, 30'd4, 30'd2
   };

endpackage

/* rtl/frsn_horner.sv */
// four-lane pipelined horner evaluator for the a, b, c and d polynomials
module frsn_horner (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  frsn_pkg::mode_type  in_mode,
   input  frsn_pkg::arg_type   in_u,
   output logic                out_valid,
   output frsn_pkg::acc_type   out_acc [frsn_pkg::NUM_POLYS]
);
   import frsn_pkg::*;

   logic     valid_ff  [0:HORNER_STEPS];
   mode_type mode_ff   [0:HORNER_STEPS-1];
   arg_type  u_ff      [0:HORNER_STEPS-1];
   acc_type  acc_ff    [0:HORNER_STEPS][NUM_POLYS];
   logic     pvalid_ff [1:HORNER_STEPS];
   mode_type pmode_ff  [1:HORNER_STEPS];
   arg_type  pu_ff     [1:HORNER_STEPS-1];
   prod_type hi_ff     [1:HORNER_STEPS][NUM_POLYS];
   prod_type lo_ff     [1:HORNER_STEPS][NUM_POLYS];
   acc_type  sum_in    [1:HORNER_STEPS][NUM_POLYS];

   // acc * u / 2^24 plus the next coefficient, modulo 2^64, from the two 32-bit halves of acc
   always_comb begin
      for (int s = 1; s <= HORNER_STEPS; s++) begin
         for (int p = 0; p < NUM_POLYS; p++) begin
            sum_in[s][p] = {hi_ff[s][p][55:0], 8'd0} + {25'd0, lo_ff[s][p][62:24]}
                         + acc_type'(coef_at(pmode_ff[s], p, s));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= HORNER_STEPS; s++) valid_ff[s] <= 1'b0;
         for (int s = 1; s <= HORNER_STEPS; s++) pvalid_ff[s] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= HORNER_STEPS; s++) begin
            pvalid_ff[s] <= valid_ff[s-1];
            valid_ff[s]  <= pvalid_ff[s];
         end
      end
      mode_ff[0] <= in_mode;
      u_ff[0]    <= in_u;
      for (int p = 0; p < NUM_POLYS; p++) begin
         acc_ff[0][p] <= acc_type'(coef_at(in_mode, p, 0));
      end
      for (int s = 1; s <= HORNER_STEPS; s++) begin
         pmode_ff[s] <= mode_ff[s-1];
         for (int p = 0; p < NUM_POLYS; p++) begin
            hi_ff[s][p]  <= 63'(acc_ff[s-1][p][63:32]) * 63'(u_ff[s-1]);
            lo_ff[s][p]  <= 63'(acc_ff[s-1][p][31:0]) * 63'(u_ff[s-1]);
            acc_ff[s][p] <= sum_in[s][p];
         end
      end
      for (int s = 1; s < HORNER_STEPS; s++) begin
         pu_ff[s]   <= u_ff[s-1];
         mode_ff[s] <= pmode_ff[s];
         u_ff[s]    <= pu_ff[s];
      end
   end

   assign out_valid = valid_ff[HORNER_STEPS];
   assign out_acc   = acc_ff[HORNER_STEPS];

endmodule

/* rtl/frsn_divider.sv */
// pipelined restoring divider, one quotient bit per stage, q2.30 result with capped integer
module frsn_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  frsn_pkg::acc_type   in_num,
   input  frsn_pkg::acc_type   in_den,
   output logic                out_valid,
   output frsn_pkg::quot_type  out_quot
);
   import frsn_pkg::*;

   typedef struct packed {
      acc_type  rem;
      acc_type  num;
      quot_type quot;
      logic     ovf;
   } div_state_type;

   logic          valid_ff [0:DIV_STEPS-1];
   div_state_type st_ff    [0:DIV_STEPS-1];
   div_state_type st_in    [0:DIV_STEPS-1];
   acc_type       den_ff   [0:DIV_STEPS-2];

   // bits shifted out of the top of the quotient mark an integer part above 3
   function automatic div_state_type div_step(input div_state_type s, input acc_type den);
      div_state_type o;
      logic [64:0]   trial;
      trial = {s.rem, s.num[63]};
      o.num = {s.num[62:0], 1'b0};
      o.ovf = s.ovf | s.quot[31];
      if (trial >= {1'b0, den}) begin
         o.rem  = 64'(trial - {1'b0, den});
         o.quot = {s.quot[30:0], 1'b1};
      end else begin
         o.rem  = trial[63:0];
         o.quot = {s.quot[30:0], 1'b0};
      end
      return o;
   endfunction

   always_comb begin
      div_state_type init;
      init.rem  = '0;
      init.num  = in_num;
      init.quot = '0;
      init.ovf  = 1'b0;
      st_in[0]  = div_step(init, in_den);
      for (int k = 1; k < DIV_STEPS; k++) begin
         st_in[k] = div_step(st_ff[k-1], den_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STEPS; k++) valid_ff[k] <= valid_ff[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) st_ff[k] <= st_in[k];
      den_ff[0] <= in_den;
      for (int k = 1; k < DIV_STEPS - 1; k++) den_ff[k] <= den_ff[k-1];
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quot  = st_ff[DIV_STEPS-1].ovf ? {2'b11, st_ff[DIV_STEPS-1].quot[29:0]}
                                             : st_ff[DIV_STEPS-1].quot;

endmodule

/* rtl/frsn_cordic.sv */
// pipelined rotation-mode cordic, one micro-rotation per stage
module frsn_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  frsn_pkg::cord_type  in_z,
   output logic                out_valid,
   output frsn_pkg::cord_type  out_x,
   output frsn_pkg::cord_type  out_y
);
   import frsn_pkg::*;

   typedef struct packed {
      cord_type x;
      cord_type y;
      cord_type z;
   } cord_state_type;

   logic           valid_ff [0:CORDIC_STEPS-1];
   cord_state_type st_ff    [0:CORDIC_STEPS-1];
   cord_state_type st_in    [0:CORDIC_STEPS-1];

   function automatic cord_state_type cord_step(input cord_state_type s, input int i);
      cord_state_type o;
      cord_type       x;
      cord_type       y;
      cord_type       z;
      x = s.x;
      y = s.y;
      z = s.z;
      if (!z[CORD_W-1]) begin
         o.x = x - (y >>> i);
         o.y = y + (x >>> i);
         o.z = z - cord_type'(ATAN_TAB[i]);
      end else begin
         o.x = x + (y >>> i);
         o.y = y - (x >>> i);
         o.z = z + cord_type'(ATAN_TAB[i]);
      end
      return o;
   endfunction

   always_comb begin
      cord_state_type init;
      init.x   = CORDIC_K;
      init.y   = '0;
      init.z   = in_z;
      st_in[0] = cord_step(init, 0);
      for (int k = 1; k < CORDIC_STEPS; k++) begin
         st_in[k] = cord_step(st_ff[k-1], k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_STEPS; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < CORDIC_STEPS; k++) valid_ff[k] <= valid_ff[k-1];
      end
      for (int k = 0; k < CORDIC_STEPS; k++) st_ff[k] <= st_in[k];
   end

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign out_x     = st_ff[CORDIC_STEPS-1].x;
   assign out_y     = st_ff[CORDIC_STEPS-1].y;

endmodule

/* rtl/fresnel_integral_rational_approx_top.sv */
// top level of the fresnel integral evaluator: C(x) and S(x) by rational approximation
// throughput: one request per cycle, set by the one-bit-per-stage dividers and cordic stages
// busy is high only while reset is asserted; the pipeline itself never holds off a request
// reset: synchronous, clears every valid bit and sets precision_mode to the 8-digit set
// results cannot be stalled by the receiver, so nothing back-pressures the pipeline
module fresnel_integral_rational_approx_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_x_value,
   input  logic               csr_wr_en,
   input  frsn_pkg::mode_type csr_wr_data,
   output logic               rsp_valid,
   output logic signed [30:0] rsp_cos_integral,
   output logic signed [30:0] rsp_sin_integral
);
   import frsn_pkg::*;

   // sideband depth: horner plus divider
   localparam int SB_DEPTH = HORNER_LAT + DIV_STEPS;
   localparam int LATENCY  = 1 + HORNER_LAT + DIV_STEPS + 1 + CORDIC_STEPS + 2;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   localparam logic signed [39:0] SAT_HI = 40'sd1073741823;
   localparam logic signed [39:0] SAT_LO = -40'sd1073741824;

   typedef struct packed {
      logic        neg;
      logic        zero;
      logic [31:0] x2;
   } side_type;

   typedef struct packed {
      logic [1:0]  quad;
      logic [32:0] amp;
      logic        neg;
      logic        zero;
   } side2_type;

   // configuration
   mode_type precision_mode_ff;

   // input stage
   logic        accept;
   logic [31:0] mag_in;
   logic [63:0] u_prod;
   logic        s1_valid_ff;
   logic        s1_neg_ff;
   logic        s1_zero_ff;
   mode_type    s1_mode_ff;
   arg_type     s1_u_ff;

   // polynomials and quotients
   logic        horner_valid;
   acc_type     horner_acc [NUM_POLYS];
   logic        ab_valid;
   logic        cd_valid;
   quot_type    ab_quot;
   quot_type    cd_quot;
   logic [61:0] x2_full;
   side_type    sb_ff [0:SB_DEPTH-1];

   // phase stage
   logic [31:0] phase_in;
   logic [60:0] theta_prod;
   logic [62:0] amp_prod;
   logic        ph_valid_ff;
   cord_type    ph_z_ff;
   side2_type   ph_side_ff;
   side2_type   s2_ff [0:CORDIC_STEPS-1];

   // cordic and output stages
   logic                 cord_valid;
   cord_type             cord_x;
   cord_type             cord_y;
   logic signed [34:0]   trig_sin_in;
   logic signed [34:0]   trig_cos_in;
   logic signed [33:0]   amp_s;
   logic                 m_valid_ff;
   logic                 m_neg_ff;
   logic                 m_zero_ff;
   logic signed [68:0]   m_sin_prod_ff;
   logic signed [68:0]   m_cos_prod_ff;
   logic                 rsp_valid_ff;
   logic signed [30:0]   rsp_cos_ff;
   logic signed [30:0]   rsp_sin_ff;

   // nothing is taken while reset holds the pipeline clear
   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_mode_ff <= MODE_RESET;
      end else if (csr_wr_en) begin
         precision_mode_ff <= csr_wr_data;
      end
   end

   // magnitude of x, then u = round(|x| * sqrt(2/pi)) in q24; -2^31 keeps magnitude 2^31
   assign mag_in = req_x_value[31] ? (~req_x_value + 32'd1) : req_x_value;
   assign u_prod = 64'(mag_in) * 64'(SQRT2PI_Q32) + 64'h0000_0000_8000_0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_neg_ff  <= req_x_value[31];
      s1_zero_ff <= (req_x_value == 32'sd0);
      s1_mode_ff <= precision_mode_ff;
      s1_u_ff    <= u_prod[62:32];
   end

   frsn_horner u_horner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_mode   (s1_mode_ff),
      .in_u      (s1_u_ff),
      .out_valid (horner_valid),
      .out_acc   (horner_acc)
   );

   // a/b gives the phase, c/d the amplitude
   frsn_divider u_div_ab (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (horner_valid),
      .in_num    (horner_acc[POLY_A]),
      .in_den    (horner_acc[POLY_B]),
      .out_valid (ab_valid),
      .out_quot  (ab_quot)
   );

   frsn_divider u_div_cd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (horner_valid),
      .in_num    (horner_acc[POLY_C]),
      .in_den    (horner_acc[POLY_D]),
      .out_valid (cd_valid),
      .out_quot  (cd_quot)
   );

   // u^2 in q30 (low 32 bits are all the modulo-4 phase needs), carried beside the dividers
   assign x2_full = 62'(s1_u_ff) * 62'(s1_u_ff);

   always_ff @(posedge clock) begin
      sb_ff[0].neg  <= s1_neg_ff;
      sb_ff[0].zero <= s1_zero_ff;
      sb_ff[0].x2   <= x2_full[49:18];
      for (int k = 1; k < SB_DEPTH; k++) sb_ff[k] <= sb_ff[k-1];
   end

   // phase in quarter turns modulo 4: top two bits pick the quadrant, the rest maps to
   // an angle below pi/2 for the cordic
   assign phase_in   = ab_quot - sb_ff[SB_DEPTH-1].x2;
   assign theta_prod = 61'(phase_in[29:0]) * 61'(HALFPI_Q30);
   assign amp_prod   = 63'(cd_quot) * 63'(SQRTPI2_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_valid_ff <= 1'b0;
      end else begin
         ph_valid_ff <= ab_valid && cd_valid;
      end
      ph_z_ff         <= cord_type'(theta_prod[60:30]);
      ph_side_ff.quad <= phase_in[31:30];
      ph_side_ff.amp  <= amp_prod[62:30];
      ph_side_ff.neg  <= sb_ff[SB_DEPTH-1].neg;
      ph_side_ff.zero <= sb_ff[SB_DEPTH-1].zero;
   end

   frsn_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ph_valid_ff),
      .in_z      (ph_z_ff),
      .out_valid (cord_valid),
      .out_x     (cord_x),
      .out_y     (cord_y)
   );

   // quadrant, amplitude, sign and zero flag ride alongside the cordic stages
   always_ff @(posedge clock) begin
      s2_ff[0] <= ph_side_ff;
      for (int k = 1; k < CORDIC_STEPS; k++) s2_ff[k] <= s2_ff[k-1];
   end

   // rotate the first-quadrant sin/cos into the quadrant of the phase
   always_comb begin
      case (s2_ff[CORDIC_STEPS-1].quad)
         QUAD_I: begin
            trig_sin_in = 35'(cord_y);
            trig_cos_in = 35'(cord_x);
         end
         QUAD_II: begin
            trig_sin_in = 35'(cord_x);
            trig_cos_in = -35'(cord_y);
         end
         QUAD_III: begin
            trig_sin_in = -35'(cord_y);
            trig_cos_in = -35'(cord_x);
         end
         default: begin
            trig_sin_in = -35'(cord_x);
            trig_cos_in = 35'(cord_y);
         end
      endcase
   end

   assign amp_s = $signed({1'b0, s2_ff[CORDIC_STEPS-1].amp});

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= cord_valid;
      end
      m_neg_ff      <= s2_ff[CORDIC_STEPS-1].neg;
      m_zero_ff     <= s2_ff[CORDIC_STEPS-1].zero;
      m_sin_prod_ff <= 69'(amp_s) * 69'(trig_sin_in);
      m_cos_prod_ff <= 69'(amp_s) * 69'(trig_cos_in);
   end

   // sgn(x) * (sqrt(pi/8) - amp * trig), floored shift, saturated into q1.30
   function automatic logic signed [30:0] finish_value(input logic signed [68:0] prod,
                                                      input logic neg);
      logic signed [39:0] v;
      v = $signed(40'(SQRTPI8_Q30)) - 40'(prod >>> FRAC_BITS);
      if (neg) v = -v;
      if (v > SAT_HI) v = SAT_HI;
      if (v < SAT_LO) v = SAT_LO;
      return 31'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= m_valid_ff;
      end
      // zero argument gives zero for both integrals
      rsp_cos_ff <= m_zero_ff ? 31'sd0 : finish_value(m_sin_prod_ff, m_neg_ff);
      rsp_sin_ff <= m_zero_ff ? 31'sd0 : finish_value(m_cos_prod_ff, m_neg_ff);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cos_integral = rsp_cos_ff;
   assign rsp_sin_integral = rsp_sin_ff;

`ifndef NO_ASSERTIONS
   // both dividers carry the same request through the same depth
   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      ab_valid == cd_valid)
      else $error("divider lanes out of step");

   // a result strobe always traces back to an accepted request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without matching request");

   // a zero argument yields zero for both integrals
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_x_value == 32'sd0, LATENCY)
         |-> rsp_cos_integral == 31'sd0 && rsp_sin_integral == 31'sd0)
      else $error("nonzero result for zero argument");

   // a cordic output strobe always traces back to a valid phase stage behind it
   a_cordic_aligned: assert property (@(posedge clock) disable iff (reset)
      cord_valid |-> $past(ph_valid_ff, CORDIC_STEPS))
      else $error("cordic valid out of step with phase stage");
`endif

endmodule
